// ===== src/v3a_pkg.sv =====
// shared types, constants and helper functions for the vector3 alu
// no dependencies; imported by every module of the block
`default_nettype none

package v3a_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int EPS_BITS  = 17;
  localparam int FUNC_BITS = 4;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int ROOT_BITS = WORD_BITS;
  localparam int QUO_BITS  = FRAC_BITS + 1;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DIFF_BITS = WORD_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [SUM_BITS-1:0]  wide_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD       = 4'd0,
    FN_SUB       = 4'd1,
    FN_CROSS     = 4'd2,
    FN_DOT       = 4'd3,
    FN_SCALE     = 4'd4,
    FN_NEGATE    = 4'd5,
    FN_NORM      = 4'd6,
    FN_SQNORM    = 4'd7,
    FN_NORMALIZE = 4'd8,
    FN_ISUNIT    = 4'd9,
    FN_COMPARE   = 4'd10
  } func_t;

  localparam word_t WMAX   = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WMIN   = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam diff_t ONE_FX = diff_t'(1) <<< FRAC_BITS;
  localparam wide_t HALF_FX = wide_t'(1) <<< (FRAC_BITS - 1);

  // result record that travels down the whole pipeline
  typedef struct packed {
    func_t             func;
    word_t [2:0]       a;
    word_t [2:0]       r;
    word_t             sc;
    logic              flag;
    logic              err;
  } res_t;

  // square root iteration state
  typedef struct packed {
    logic [PROD_BITS-1:0] s;
    logic [ROOT_BITS-1:0] root;
    logic [ROOT_BITS+2:0] rem;
  } sq_t;

  // one divider lane
  typedef struct packed {
    logic [NUM_BITS-1:0]  num;
    logic [QUO_BITS-1:0]  q;
    logic [ROOT_BITS:0]   rem;
  } dv_t;

  function automatic word_t sat_sum(input logic signed [WORD_BITS:0] v);
    word_t res;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      res = v[WORD_BITS] ? WMIN : WMAX;
    end else begin
      res = word_t'(v[WORD_BITS-1:0]);
    end
    return res;
  endfunction

  // round to nearest (ties up) from the exact product sum, then saturate
  function automatic word_t round_sat(input wide_t e);
    wide_t t;
    word_t res;
    t = (e + HALF_FX) >>> FRAC_BITS;
    if (t > wide_t'(WMAX)) begin
      res = WMAX;
    end else if (t < wide_t'(WMIN)) begin
      res = WMIN;
    end else begin
      res = word_t'(t[WORD_BITS-1:0]);
    end
    return res;
  endfunction

  // |d| < eps
  function automatic logic in_tol(input diff_t d, input logic [EPS_BITS-1:0] eps);
    diff_t pe;
    pe = diff_t'({{(DIFF_BITS-EPS_BITS){1'b0}}, eps});
    return (d < pe) && (d > -pe);
  endfunction

endpackage

`default_nettype wire

// ===== src/v3a_front.sv =====
// front end: operand select, multipliers, product sums, rounding and simple ops
// depends on v3a_pkg
`default_nettype none

module v3a_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic [v3a_pkg::EPS_BITS-1:0]     eps,
  input  wire logic                             in_valid,
  input  wire logic [v3a_pkg::FUNC_BITS-1:0]    in_func,
  input  wire v3a_pkg::word_t                   in_a [3],
  input  wire v3a_pkg::word_t                   in_b [3],
  input  wire v3a_pkg::word_t                   in_f,
  output logic                                  out_valid,
  output v3a_pkg::res_t                         out_res,
  output logic [v3a_pkg::PROD_BITS-1:0]         out_s
);
  import v3a_pkg::*;

  // stage 1: captured item
  logic  v1;
  func_t func1;
  word_t a1 [3];
  word_t b1 [3];
  word_t f1;

  // stage 2: multiplier operands and simple results
  logic  v2;
  func_t func2;
  word_t a2 [3];
  word_t opx2 [6];
  word_t opy2 [6];
  word_t rs2 [3];
  logic  cmp2;
  logic  zero2;

  // stage 3: products
  logic  v3;
  func_t func3;
  word_t a3 [3];
  word_t rs3 [3];
  logic  cmp3;
  logic  zero3;
  logic signed [PROD_BITS-1:0] prod3 [6];

  // stage 4: exact sums
  logic  v4;
  func_t func4;
  word_t a4 [3];
  word_t rs4 [3];
  logic  cmp4;
  logic  zero4;
  wide_t e4 [3];

  // stage 5: rounded values
  logic  v5;
  func_t func5;
  word_t a5 [3];
  word_t rs5 [3];
  logic  cmp5;
  logic  zero5;
  word_t rnd5 [3];
  logic [PROD_BITS-1:0] s5;

  word_t opx_c [6];
  word_t opy_c [6];
  word_t rs_c [3];
  logic  cmp_c;
  logic  zero_c;
  logic signed [PROD_BITS-1:0] prod_c [6];
  wide_t e_c [3];
  word_t rnd_c [3];
  res_t  res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1 <= func_t'(in_func);
      a1    <= in_a;
      b1    <= in_b;
      f1    <= in_f;
    end
  end

  // operand routing and the add, sub, negate, compare paths
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      opx_c[k] = '0;
      opy_c[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      opx_c[k] = a1[k];
      opy_c[k] = b1[k];
      rs_c[k]  = '0;
    end
    case (func1)
      FN_CROSS: begin
        opx_c[0] = a1[1]; opy_c[0] = b1[2];
        opx_c[1] = a1[2]; opy_c[1] = b1[1];
        opx_c[2] = a1[2]; opy_c[2] = b1[0];
        opx_c[3] = a1[0]; opy_c[3] = b1[2];
        opx_c[4] = a1[0]; opy_c[4] = b1[1];
        opx_c[5] = a1[1]; opy_c[5] = b1[0];
      end
      FN_SCALE: begin
        for (int k = 0; k < 3; k++) opx_c[k] = f1;
        for (int k = 0; k < 3; k++) opy_c[k] = a1[k];
      end
      FN_NORM, FN_SQNORM, FN_NORMALIZE, FN_ISUNIT: begin
        for (int k = 0; k < 3; k++) opy_c[k] = a1[k];
      end
      FN_ADD: begin
        for (int k = 0; k < 3; k++)
          rs_c[k] = sat_sum((WORD_BITS+1)'(a1[k]) + (WORD_BITS+1)'(b1[k]));
      end
      FN_SUB: begin
        for (int k = 0; k < 3; k++)
          rs_c[k] = sat_sum((WORD_BITS+1)'(a1[k]) - (WORD_BITS+1)'(b1[k]));
      end
      FN_NEGATE: begin
        for (int k = 0; k < 3; k++)
          rs_c[k] = (a1[k] == WMIN) ? WMAX : -a1[k];
      end
      default: begin
      end
    endcase
    cmp_c = 1'b1;
    for (int k = 0; k < 3; k++)
      cmp_c = cmp_c & in_tol(diff_t'(a1[k]) - diff_t'(b1[k]), eps);
    zero_c = (a1[0] == '0) && (a1[1] == '0) && (a1[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func2 <= func1;
      a2    <= a1;
      opx2  <= opx_c;
      opy2  <= opy_c;
      rs2   <= rs_c;
      cmp2  <= cmp_c;
      zero2 <= zero_c;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) prod_c[k] = opx2[k] * opy2[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func3 <= func2;
      a3    <= a2;
      rs3   <= rs2;
      cmp3  <= cmp2;
      zero3 <= zero2;
      prod3 <= prod_c;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) e_c[k] = '0;
    case (func3)
      FN_CROSS: begin
        for (int k = 0; k < 3; k++)
          e_c[k] = wide_t'(prod3[2*k]) - wide_t'(prod3[2*k+1]);
      end
      FN_SCALE: begin
        for (int k = 0; k < 3; k++) e_c[k] = wide_t'(prod3[k]);
      end
      default: begin
        e_c[0] = wide_t'(prod3[0]) + wide_t'(prod3[1]) + wide_t'(prod3[2]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func4 <= func3;
      a4    <= a3;
      rs4   <= rs3;
      cmp4  <= cmp3;
      zero4 <= zero3;
      e4    <= e_c;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) rnd_c[k] = round_sat(e4[k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func5 <= func4;
      a5    <= a4;
      rs5   <= rs4;
      cmp5  <= cmp4;
      zero5 <= zero4;
      rnd5  <= rnd_c;
      // sum of squares is never negative
      s5    <= e4[0][PROD_BITS-1:0];
    end
  end

  always_comb begin
    res_c      = '0;
    res_c.func = func5;
    for (int k = 0; k < 3; k++) res_c.a[k] = a5[k];
    case (func5)
      FN_ADD, FN_SUB, FN_NEGATE: begin
        for (int k = 0; k < 3; k++) res_c.r[k] = rs5[k];
      end
      FN_CROSS, FN_SCALE: begin
        for (int k = 0; k < 3; k++) res_c.r[k] = rnd5[k];
      end
      FN_DOT, FN_SQNORM: res_c.sc = rnd5[0];
      FN_ISUNIT:    res_c.flag = in_tol(diff_t'(rnd5[0]) - ONE_FX, eps);
      FN_COMPARE:   res_c.flag = cmp5;
      FN_NORMALIZE: res_c.err  = zero5;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_c;
      out_s   <= s5;
    end
  end

endmodule

`default_nettype wire

// ===== src/v3a_sqrt.sv =====
// pipelined square root, one root bit per stage, then round to nearest
// depends on v3a_pkg
`default_nettype none

module v3a_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire v3a_pkg::res_t                 in_res,
  input  wire logic [v3a_pkg::PROD_BITS-1:0] in_s,
  output logic                               out_valid,
  output v3a_pkg::res_t                      out_res,
  output logic [v3a_pkg::ROOT_BITS-1:0]      out_n
);
  import v3a_pkg::*;

  localparam int ITER = ROOT_BITS;

  logic vld [0:ITER];
  res_t res [0:ITER];
  sq_t  sq  [0:ITER];

  logic [ROOT_BITS:0] n_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res[0]     <= in_res;
      sq[0].s    <= in_s;
      sq[0].root <= '0;
      sq[0].rem  <= '0;
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_step
    localparam int P = 2 * (ITER - k);
    logic [ROOT_BITS+2:0] rem_sh;
    logic [ROOT_BITS+2:0] trial;
    sq_t                  nxt;

    always_comb begin
      rem_sh = {sq[k-1].rem[ROOT_BITS:0], sq[k-1].s[P+1:P]};
      trial  = {1'b0, sq[k-1].root, 2'b01};
      nxt    = sq[k-1];
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {sq[k-1].root[ROOT_BITS-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {sq[k-1].root[ROOT_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res[k] <= res[k-1];
        sq[k]  <= nxt;
      end
    end
  end

  // round up when the remainder exceeds the floor root
  assign n_c = {1'b0, sq[ITER].root}
             + (ROOT_BITS+1)'(sq[ITER].rem > {3'b000, sq[ITER].root});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res[ITER];
      out_n   <= n_c[ROOT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/v3a_div.sv =====
// pipelined restoring divider, three lanes, one quotient bit per stage
// computes round(|a_i| * 2^frac / n) for normalize; depends on v3a_pkg
`default_nettype none

module v3a_div (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire v3a_pkg::res_t                          in_res,
  input  wire logic [v3a_pkg::ROOT_BITS-1:0]          in_n,
  output logic                                        out_valid,
  output v3a_pkg::res_t                               out_res,
  output logic [v3a_pkg::ROOT_BITS-1:0]               out_n,
  output logic [2:0][v3a_pkg::QUO_BITS-1:0]           out_q
);
  import v3a_pkg::*;

  localparam int STEPS = QUO_BITS;

  logic                 vld  [0:STEPS];
  res_t                 res  [0:STEPS];
  logic [ROOT_BITS-1:0] dvs  [0:STEPS];
  dv_t                  lane [0:STEPS][3];

  dv_t                  prep [3];
  logic [WORD_BITS-1:0] mag  [3];

  // rounding adds half the divisor; the quotient never exceeds one
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = in_res.a[k][WORD_BITS-1] ? WORD_BITS'(-in_res.a[k])
                                         : WORD_BITS'(in_res.a[k]);
      prep[k].num = {mag[k], {FRAC_BITS{1'b0}}} + NUM_BITS'(in_n >> 1);
      prep[k].q   = '0;
      prep[k].rem = (ROOT_BITS+1)'(prep[k].num[NUM_BITS-1:QUO_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res[0]  <= in_res;
      dvs[0]  <= in_n;
      lane[0] <= prep;
    end
  end

  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam int IDX = STEPS - j;
    dv_t nxt [3];

    always_comb begin
      logic [ROOT_BITS:0] rem_sh;
      logic               ge;
      for (int k = 0; k < 3; k++) begin
        rem_sh     = {lane[j-1][k].rem[ROOT_BITS-1:0], lane[j-1][k].num[IDX]};
        ge         = rem_sh >= {1'b0, dvs[j-1]};
        nxt[k]     = lane[j-1][k];
        nxt[k].rem = ge ? rem_sh - {1'b0, dvs[j-1]} : rem_sh;
        nxt[k].q   = {lane[j-1][k].q[QUO_BITS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res[j]  <= res[j-1];
        dvs[j]  <= dvs[j-1];
        lane[j] <= nxt;
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_res   = res[STEPS];
  assign out_n     = dvs[STEPS];
  always_comb begin
    for (int k = 0; k < 3; k++) out_q[k] = lane[STEPS][k].q;
  end

endmodule

`default_nettype wire

// ===== src/vector3_alu_top.sv =====
// top level of the three-component vector alu: epsilon register, pipeline
// units, result select and output register with skid entry; uses v3a_pkg
//
//  channel | direction | handshake             | payload
//  in      | in        | in_valid / in_stall   | func, a_x..a_z, b_x..b_z, factor
//  out     | out       | out_valid / out_stall | r_x, r_y, r_z, scalar_out, flag, error
//  cfg     | in        | cfg_valid / cfg_ready | epsilon
//
// one item per cycle while the pipeline is not stalled; out_valid follows the input transfer
// through 59 register stages: 6 front, 34 square root, 18 divider, output register
// the square root and divider each resolve one bit per stage and set the depth
// synchronous reset clears all valid bits and sets epsilon to 1
// a stalled output first fills a one-entry skid, then the pipeline holds
// in_stall is registered and follows only the skid entry
`default_nettype none

module vector3_alu_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [v3a_pkg::FUNC_BITS-1:0] func,
  input  wire v3a_pkg::word_t                a_x,
  input  wire v3a_pkg::word_t                a_y,
  input  wire v3a_pkg::word_t                a_z,
  input  wire v3a_pkg::word_t                b_x,
  input  wire v3a_pkg::word_t                b_y,
  input  wire v3a_pkg::word_t                b_z,
  input  wire v3a_pkg::word_t                factor,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output v3a_pkg::word_t                     r_x,
  output v3a_pkg::word_t                     r_y,
  output v3a_pkg::word_t                     r_z,
  output v3a_pkg::word_t                     scalar_out,
  output logic                               flag,
  output logic                               error,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [v3a_pkg::EPS_BITS-1:0]  epsilon
);
  import v3a_pkg::*;

  logic [EPS_BITS-1:0] eps;
  logic                en;
  logic                skid_valid;
  res_t                skid;
  res_t                out_q;

  word_t in_a [3];
  word_t in_b [3];

  logic                 fe_valid;
  res_t                 fe_res;
  logic [PROD_BITS-1:0] fe_s;
  logic                 sq_valid;
  res_t                 sq_res;
  logic [ROOT_BITS-1:0] sq_n;
  logic                 dv_valid;
  res_t                 dv_res;
  logic [ROOT_BITS-1:0] dv_n;
  logic [2:0][QUO_BITS-1:0] dv_q;
  res_t                 fin;
  word_t                qw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      eps <= epsilon;
    end
  end

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  assign in_a[0] = a_x;
  assign in_a[1] = a_y;
  assign in_a[2] = a_z;
  assign in_b[0] = b_x;
  assign in_b[1] = b_y;
  assign in_b[2] = b_z;

  v3a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .eps       (eps),
    .in_valid  (in_valid),
    .in_func   (func),
    .in_a      (in_a),
    .in_b      (in_b),
    .in_f      (factor),
    .out_valid (fe_valid),
    .out_res   (fe_res),
    .out_s     (fe_s)
  );

  v3a_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fe_valid),
    .in_res    (fe_res),
    .in_s      (fe_s),
    .out_valid (sq_valid),
    .out_res   (sq_res),
    .out_n     (sq_n)
  );

  v3a_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_res    (sq_res),
    .in_n      (sq_n),
    .out_valid (dv_valid),
    .out_res   (dv_res),
    .out_n     (dv_n),
    .out_q     (dv_q)
  );

  // fill in norm and normalize results
  always_comb begin
    fin = dv_res;
    qw  = '0;
    case (dv_res.func)
      FN_NORM: begin
        fin.sc = (dv_n > ROOT_BITS'(WMAX)) ? WMAX : word_t'(dv_n);
      end
      FN_NORMALIZE: begin
        if (!dv_res.err) begin
          for (int k = 0; k < 3; k++) begin
            qw = word_t'(dv_q[k]);
            fin.r[k] = dv_res.a[k][WORD_BITS-1] ? -qw : qw;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && out_stall) begin
      skid_valid <= dv_valid;
    end else begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_q <= skid;
      end
    end else if (out_valid && out_stall) begin
      skid <= fin;
    end else begin
      out_q <= fin;
    end
  end

  assign r_x        = out_q.r[0];
  assign r_y        = out_q.r[1];
  assign r_z        = out_q.r[2];
  assign scalar_out = out_q.sc;
  assign flag       = out_q.flag;
  assign error      = out_q.err;

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a valid output");

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (r_x == '0 && r_y == '0 && r_z == '0 &&
                              scalar_out == '0 && !flag))
    else $error("normalize error with nonzero result");

  a_flag_alone : assert property (@(posedge clk) disable iff (rst)
    (out_valid && flag) |-> (r_x == '0 && r_y == '0 && r_z == '0 &&
                             scalar_out == '0 && !error))
    else $error("flag result carries other fields");

  a_skid_drain : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output");

endmodule

`default_nettype wire

// ===== tb/vector3_alu_top_tb.sv =====
// testbench for vector3_alu_top: directed and random vector operations
// checked against a cycle-free behavioral predictor; uses v3a_pkg
`timescale 1ns / 1ps
`default_nettype none

module vector3_alu_top_tb;
  import v3a_pkg::*;

  typedef logic signed [127:0] big_t;

  typedef struct {
    logic [FUNC_BITS-1:0] func;
    word_t ax, ay, az, bx, by, bz, factor;
  } vec_req_t;

  typedef struct {
    word_t rx, ry, rz, sc;
    logic  flag, err;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_BITS-1:0] func = '0;
  word_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0, factor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t r_x, r_y, r_z, scalar_out;
  logic flag, error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [EPS_BITS-1:0] epsilon = 17'd1;

  vec_res_t pending_results[$];
  logic [EPS_BITS-1:0] tol = 17'd1;
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  always #2 clk = ~clk;

  vector3_alu_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .factor(factor),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .scalar_out(scalar_out),
    .flag(flag), .error(error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .epsilon(epsilon)
  );

  // ---------------- predictor ----------------
  function automatic big_t wmul(input word_t u, input word_t v);
    big_t x, y;
    x = u;
    y = v;
    return x * y;
  endfunction

  // nearest, ties toward plus infinity, then saturate
  function automatic word_t round_q(input big_t e);
    big_t t;
    t = (e + 128'sd32768) >>> FRAC_BITS;
    if (t > 128'sd2147483647) return WMAX;
    if (t < -128'sd2147483648) return WMIN;
    return word_t'(t[31:0]);
  endfunction

  function automatic word_t clamp(input longint v);
    if (v > 64'sd2147483647) return WMAX;
    if (v < -64'sd2147483648) return WMIN;
    return word_t'(v[31:0]);
  endfunction

  function automatic bit [63:0] root_nearest(input bit [63:0] s);
    bit [63:0] rem, r, b;
    rem = s;
    r = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic vec_res_t vector_result(input vec_req_t q, input logic [EPS_BITS-1:0] eps);
    vec_res_t o;
    word_t sq;
    bit [63:0] ss, n, m;
    longint qt;
    word_t av[3], bv[3], rv[3];
    o = '{default: '0};
    av = '{q.ax, q.ay, q.az};
    bv = '{q.bx, q.by, q.bz};
    rv = '{0, 0, 0};
    ss = 0;
    for (int i = 0; i < 3; i++) ss += 64'(wmul(av[i], av[i]));
    sq = round_q(wmul(q.ax, q.ax) + wmul(q.ay, q.ay) + wmul(q.az, q.az));
    case (q.func)
      FN_ADD:  for (int i = 0; i < 3; i++) rv[i] = clamp(longint'(av[i]) + longint'(bv[i]));
      FN_SUB:  for (int i = 0; i < 3; i++) rv[i] = clamp(longint'(av[i]) - longint'(bv[i]));
      FN_CROSS: begin
        rv[0] = round_q(wmul(q.ay, q.bz) - wmul(q.az, q.by));
        rv[1] = round_q(wmul(q.az, q.bx) - wmul(q.ax, q.bz));
        rv[2] = round_q(wmul(q.ax, q.by) - wmul(q.ay, q.bx));
      end
      FN_DOT:
        o.sc = round_q(wmul(q.ax, q.bx) + wmul(q.ay, q.by) + wmul(q.az, q.bz));
      FN_SCALE: for (int i = 0; i < 3; i++) rv[i] = round_q(wmul(q.factor, av[i]));
      FN_NEGATE: for (int i = 0; i < 3; i++) rv[i] = clamp(-longint'(av[i]));
      FN_NORM: begin
        n = root_nearest(ss);
        o.sc = n > 64'd2147483647 ? WMAX : word_t'(n[31:0]);
      end
      FN_SQNORM: o.sc = sq;
      FN_NORMALIZE: begin
        if (q.ax == 0 && q.ay == 0 && q.az == 0) begin
          o.err = 1'b1;
        end else begin
          n = root_nearest(ss);
          for (int i = 0; i < 3; i++) begin
            // quotient rounds half away from zero
            m = 64'(mag(av[i])) << FRAC_BITS;
            qt = longint'((m + n / 2) / n);
            rv[i] = clamp(av[i] < 0 ? -qt : qt);
          end
        end
      end
      FN_ISUNIT: o.flag = mag(longint'(sq) - 65536) < longint'(eps);
      FN_COMPARE:
        o.flag = mag(longint'(q.ax) - q.bx) < longint'(eps) &&
                 mag(longint'(q.ay) - q.by) < longint'(eps) &&
                 mag(longint'(q.az) - q.bz) < longint'(eps);
      default: ;
    endcase
    o.rx = rv[0];
    o.ry = rv[1];
    o.rz = rv[2];
    return o;
  endfunction

  // ---------------- drivers ----------------
  // entered and left at a falling edge; valid stays high across back-to-back items
  task automatic send_item(input vec_req_t q);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= q.func;
    a_x <= q.ax; a_y <= q.ay; a_z <= q.az;
    b_x <= q.bx; b_y <= q.by; b_z <= q.bz;
    factor <= q.factor;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(vector_result(q, tol));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [EPS_BITS-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    epsilon <= v;
    do @(posedge clk); while (!cfg_ready);
    tol = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: random stall, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    vec_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (r_x !== e.rx) begin $error("r_x exp %0d got %0d", e.rx, r_x); errors++; end
        if (r_y !== e.ry) begin $error("r_y exp %0d got %0d", e.ry, r_y); errors++; end
        if (r_z !== e.rz) begin $error("r_z exp %0d got %0d", e.rz, r_z); errors++; end
        if (scalar_out !== e.sc) begin
          $error("scalar_out exp %0d got %0d", e.sc, scalar_out); errors++;
        end
        if (flag !== e.flag) begin $error("flag exp %0b got %0b", e.flag, flag); errors++; end
        if (error !== e.err) begin $error("error exp %0b got %0b", e.err, error); errors++; end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic vec_req_t mk(input logic [3:0] f, input word_t ax, input word_t ay,
                                  input word_t az, input word_t bx, input word_t by,
                                  input word_t bz, input word_t fc);
    vec_req_t q;
    q.func = f;
    q.ax = ax; q.ay = ay; q.az = az;
    q.bx = bx; q.by = by; q.bz = bz;
    q.factor = fc;
    return q;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: case ($urandom_range(5))
           0: return WMAX;
           1: return WMIN;
           2: return 0;
           3: return -1;
           4: return 1;
           default: return 32'sh10000;
         endcase
      1, 2, 3: return word_t'($urandom);
      default: return word_t'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  function automatic word_t near(input word_t c, input int spread);
    return word_t'(longint'(c) + longint'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic vec_req_t rand_item();
    vec_req_t q;
    int s;
    q = mk(4'($urandom_range(10)), rand_word(), rand_word(), rand_word(),
           rand_word(), rand_word(), rand_word(), rand_word());
    if ($urandom_range(19) == 0) q.func = 4'($urandom_range(11, 15));
    s = int'(tol) / 2 + 16;
    case (q.func)
      FN_ISUNIT: if ($urandom_range(3) != 0) begin
        q.ax = near(32'sh10000, s);
        q.ay = near(0, 64);
        q.az = near(0, 64);
      end
      FN_COMPARE: if ($urandom_range(3) != 0) begin
        q.bx = near(q.ax, int'(tol) + 2);
        q.by = near(q.ay, int'(tol) + 2);
        q.bz = near(q.az, int'(tol) + 2);
      end
      FN_NORMALIZE: if ($urandom_range(7) == 0) begin
        q.ax = 0; q.ay = 0; q.az = 0;
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic test_directed();
    send_item(mk(FN_ADD, WMAX, WMIN, 5, WMAX, WMIN, -7, 0));
    send_item(mk(FN_SUB, WMIN, WMAX, 0, WMAX, WMIN, 1, 0));
    send_item(mk(FN_CROSS, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0));
    send_item(mk(FN_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0));
    send_item(mk(FN_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0));
    send_item(mk(FN_DOT, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, 0));
    // half-lsb ties in both directions
    send_item(mk(FN_SCALE, 32'sh8000, -32'sh8000, 32'sh18000, 0, 0, 0, 1));
    send_item(mk(FN_SCALE, WMIN, WMAX, 3, 0, 0, 0, WMIN));
    send_item(mk(FN_NEGATE, WMIN, WMAX, 0, 0, 0, 0, 0));
    send_item(mk(FN_NORM, WMIN, WMIN, WMIN, 0, 0, 0, 0));
    send_item(mk(FN_NORM, 3 <<< 16, 4 <<< 16, 0, 0, 0, 0, 0));
    send_item(mk(FN_SQNORM, WMAX, 0, 0, 0, 0, 0, 0));
    send_item(mk(FN_NORMALIZE, 0, 0, 0, 1, 2, 3, 4));
    send_item(mk(FN_NORMALIZE, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk(FN_NORMALIZE, WMIN, 0, 0, 0, 0, 0, 0));
    send_item(mk(FN_NORMALIZE, -5, 7, WMAX, 0, 0, 0, 0));
    send_item(mk(FN_ISUNIT, 32'sh10000, 0, 0, 0, 0, 0, 0));
    send_item(mk(FN_ISUNIT, 32'sh10001, 0, 0, 0, 0, 0, 0));
    send_item(mk(FN_COMPARE, 5, -5, WMIN, 5, -5, WMIN, 0));
    send_item(mk(FN_COMPARE, 5, -5, WMIN, 6, -5, WMIN, 0));
    send_item(mk(FN_COMPARE, WMAX, 0, 0, WMIN, 0, 0, 0));
    send_item(mk(4'd11, 1, 2, 3, 4, 5, 6, 7));
    send_item(mk(4'd15, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
  endtask

  task automatic test_tolerance_edges();
    logic [EPS_BITS-1:0] settings[3];
    settings = '{17'd0, 17'd65536, 17'd100};
    foreach (settings[k]) begin
      write_tolerance(settings[k]);
      send_item(mk(FN_COMPARE, 7, 7, 7, 7, 7, 7, 0));
      send_item(mk(FN_COMPARE, 0, 0, 0, 32'sh10000, 0, 0, 0));
      send_item(mk(FN_COMPARE, 0, 0, 0, 32'shFFFF, -32'shFFFF, 0, 0));
      send_item(mk(FN_ISUNIT, 32'sh10000, 0, 0, 0, 0, 0, 0));
      send_item(mk(FN_ISUNIT, 0, 0, 0, 0, 0, 0, 0));
      repeat (40) send_item(rand_item());
    end
  endtask

  task automatic test_random_phases();
    int idle_set[5];
    int stall_set[5];
    idle_set = '{0, 63, 0, 14, 0};
    stall_set = '{0, 0, 63, 14, 0};
    for (int p = 0; p < 5; p++) begin
      write_tolerance(17'($urandom_range(1, 65535)));
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      repeat (350) send_item(rand_item());
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    repeat (150) send_item(rand_item());
    // sender waits for every outstanding result, then resumes
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) send_item(rand_item());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_tolerance_edges();
    test_random_phases();
    test_backpressure();
    write_tolerance(17'd1);
    repeat (20) send_item(rand_item());
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
